/* design/replicated_log_store_unit_defines.svh */
// Assertion macros for the replicated log store unit.
// The asserting module must provide clk and arst_n.
`ifndef REPLICATED_LOG_STORE_UNIT_DEFINES_SVH
`define REPLICATED_LOG_STORE_UNIT_DEFINES_SVH

// Assert a property that holds at every clock edge outside reset.
`define RLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that the consequent holds in the cycle after the antecedent.
`define RLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rls_pkg.sv */
// ----------------------------------------------------------------------------
// rls_pkg
// Types and constants shared by the replicated log store unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rls_pkg;

	localparam int IDX_W  = 11;
	localparam int TERM_W = 31;
	localparam int CMD_W  = 8;
	localparam int WORD_W = 64;
	localparam int IN_W   = 224;
	localparam int OUT_W  = 216;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_BATCH  = 2'd1,
		REQ_HEART  = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t           req_type;
		logic                first_of_batch;
		logic [IDX_W-1:0]    prev_index;
		logic [TERM_W-1:0]   prev_term;
		logic [IDX_W-1:0]    read_index;
		logic [TERM_W-1:0]   entry_term;
		logic [CMD_W-1:0]    entry_command;
		logic [WORD_W-1:0]   entry_key;
		logic [WORD_W-1:0]   entry_value;
	} req_t;

	typedef struct packed {
		logic                accepted;
		logic                log_full;
		logic [IDX_W-1:0]    last_index;
		logic [TERM_W-1:0]   last_term;
		logic [TERM_W-1:0]   read_term;
		logic [CMD_W-1:0]    read_command;
		logic [WORD_W-1:0]   read_key;
		logic [WORD_W-1:0]   read_value;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_HB,
		ST_CHK,
		ST_BAT,
		ST_CMP,
		ST_RD
	} state_t;

endpackage

/* design/replicated_log_store_unit.sv */
// ----------------------------------------------------------------------------
// replicated_log_store_unit
// Consensus log store with local append, leader batch, heartbeat and read.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the request kind and
// s_tdata the request fields. Every request gives exactly one result item on
// the m_ stream, in request order.
// A two-entry queue decouples input acceptance from execution, so requests
// keep arriving while a result waits for the receiver.
// A request is taken from the queue in the idle state and decoded in the
// decode state, where an append or a request decided without a table lookup
// is settled. A read or a heartbeat reads the log in the decode state and is
// settled in its own state; a batch entry goes on to the batch state, where it
// is refused, appends, or reads the log for the compare state, and the first
// entry of a batch may first read and check the previous entry. Each term
// lookup costs one registered read of the log memory, which has a single read
// port. The back end works on one request at a time, so it takes a new one only after loading the result of the last.
// The back end starts the next request only when the result register is free
// or emptying, so a stalled receiver first fills the queue and then holds
// s_tready low.
// Reset empties the log and clears batch tracking; the memories themselves are
// not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "replicated_log_store_unit_defines.svh"

module replicated_log_store_unit #(
	parameter int LOG_DEPTH    = 1024,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// first_of_batch, prev_index, prev_term, read_index, entry_term,
	// entry_command, entry_key, entry_value, zero fill
	input  logic [rls_pkg::IN_W-1:0]  s_tdata,
	// req_type
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// accepted, log_full, last_index, last_term, read_term, read_command,
	// read_key, read_value, zero fill
	output logic [rls_pkg::OUT_W-1:0] m_tdata
);

	logic          q_valid;
	logic          q_ready;
	rls_pkg::req_t q_req;
	rls_pkg::res_t res;

	rls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	rls_back #(
		.LOG_DEPTH    (LOG_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_req     (q_req),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {5'd0, res.read_value, res.read_key, res.read_command, res.read_term,
		res.last_term, res.last_index, res.log_full, res.accepted};

	`RLS_ASSERT(a_acc_full_excl, !(m_tvalid && m_tdata[0] && m_tdata[1]), "accepted and log_full both set")
	`RLS_ASSERT(a_full_count, !(m_tvalid && m_tdata[1]) || (m_tdata[12:2] == rls_pkg::IDX_W'(LOG_DEPTH)), "log_full with a log that is not full")
	`RLS_ASSERT_NEXT(a_pop_out_free, q_valid && q_ready, !m_tvalid, "request started while a result was still held")

endmodule

/* design/rls_front.sv */
// ----------------------------------------------------------------------------
// rls_front
// Input side: takes stream items, unpacks them and queues two requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rls_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [rls_pkg::IN_W-1:0]  s_tdata,
	input  logic [1:0]                s_tuser,
	output logic                      q_valid,
	input  logic                      q_ready,
	output rls_pkg::req_t             q_req
);

	rls_pkg::req_t slot_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    fill_q;
	rls_pkg::req_t in_req;
	logic          push;
	logic          pop;

	always_comb begin
		in_req.req_type       = rls_pkg::req_kind_t'(s_tuser);
		in_req.first_of_batch = s_tdata[0];
		in_req.prev_index     = s_tdata[11:1];
		in_req.prev_term      = s_tdata[42:12];
		in_req.read_index     = s_tdata[53:43];
		in_req.entry_term     = s_tdata[84:54];
		in_req.entry_command  = s_tdata[92:85];
		in_req.entry_key      = s_tdata[156:93];
		in_req.entry_value    = s_tdata[220:157];
	end

	assign s_tready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_req    = slot_q[rptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/rls_back.sv */
// ----------------------------------------------------------------------------
// rls_back
// Execution side: log memories, entry count, batch tracking and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rls_back #(
	parameter int LOG_DEPTH    = 1024,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  rls_pkg::req_t              q_req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rls_pkg::res_t              res
);

	localparam int AW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW  = $clog2(LOG_DEPTH + 1);
	localparam int CUW = CW + 1;
	localparam int XW  = (CW > rls_pkg::IDX_W) ? CW : rls_pkg::IDX_W;

	logic [rls_pkg::TERM_W-1:0] term_mem  [LOG_DEPTH];
	logic [rls_pkg::CMD_W-1:0]  cmd_mem   [LOG_DEPTH];
	logic [PAYLOAD_BITS-1:0]    key_mem   [LOG_DEPTH];
	logic [PAYLOAD_BITS-1:0]    val_mem   [LOG_DEPTH];

	logic [rls_pkg::TERM_W-1:0] rd_term_q;
	logic [rls_pkg::CMD_W-1:0]  rd_cmd_q;
	logic [PAYLOAD_BITS-1:0]    rd_key_q;
	logic [PAYLOAD_BITS-1:0]    rd_val_q;

	rls_pkg::state_t            state_q, state_d;
	rls_pkg::req_t              cur_q;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic [CUW-1:0]             cursor_q, cursor_d;
	logic                       match_q, match_d;
	logic                       rej_q, rej_d;
	logic [rls_pkg::TERM_W-1:0] last_term_q, last_term_d;
	logic                       res_valid_q;
	rls_pkg::res_t              res_q;

	logic                       pop;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic                       res_load;
	logic                       res_acc;
	logic                       res_full;
	logic                       res_is_read;
	logic                       do_push;
	logic                       push_batch;
	logic [CW-1:0]              push_base;
	logic [XW-1:0]              p_x;
	logic [XW-1:0]              r_x;
	logic [XW-1:0]              cnt_x;
	logic [CUW-1:0]             cnt_u;
	logic                       out_free;

	assign out_free = !res_valid_q || res_ready;
	assign p_x      = XW'(cur_q.prev_index);
	assign r_x      = XW'(cur_q.read_index);
	assign cnt_x    = XW'(cnt_q);
	assign cnt_u    = CUW'(cnt_q);

	// Actions of each state.
	always_comb begin
		pop         = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		res_load    = 1'b0;
		res_acc     = 1'b0;
		res_full    = 1'b0;
		res_is_read = 1'b0;
		do_push     = 1'b0;
		push_batch  = 1'b0;
		push_base   = cnt_q;
		cnt_d       = cnt_q;
		cursor_d    = cursor_q;
		match_d     = match_q;
		rej_d       = rej_q;
		last_term_d = last_term_q;
		unique case (state_q)
			rls_pkg::ST_IDLE: begin
				pop = q_valid && out_free;
			end
			rls_pkg::ST_DEC: begin
				unique case (cur_q.req_type)
					rls_pkg::REQ_APPEND: begin
						do_push = 1'b1;
					end
					rls_pkg::REQ_HEART: begin
						if (p_x == '0) begin
							res_load = 1'b1;
							res_acc  = (cur_q.prev_term == '0);
						end else if (p_x > cnt_x) begin
							res_load = 1'b1;
						end else begin
							rd_en   = 1'b1;
							rd_addr = AW'(p_x - 1'b1);
						end
					end
					rls_pkg::REQ_READ: begin
						if (r_x != '0 && r_x <= cnt_x) begin
							rd_en   = 1'b1;
							rd_addr = AW'(r_x - 1'b1);
						end else begin
							res_load = 1'b1;
						end
					end
					rls_pkg::REQ_BATCH: begin
						if (cur_q.first_of_batch) begin
							if (p_x == '0) begin
								if (cur_q.prev_term == '0) begin
									rej_d    = 1'b0;
									match_d  = 1'b1;
									cursor_d = CUW'(1);
								end else begin
									rej_d    = 1'b1;
									match_d  = 1'b0;
									res_load = 1'b1;
								end
							end else if (p_x > cnt_x) begin
								rej_d    = 1'b1;
								match_d  = 1'b0;
								res_load = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(p_x - 1'b1);
							end
						end
					end
					default: begin
					end
				endcase
			end
			rls_pkg::ST_HB: begin
				res_load = 1'b1;
				res_acc  = (rd_term_q == cur_q.prev_term);
			end
			rls_pkg::ST_CHK: begin
				if (rd_term_q == cur_q.prev_term) begin
					rej_d    = 1'b0;
					match_d  = 1'b1;
					cursor_d = CUW'(p_x) + 1'b1;
				end else begin
					rej_d    = 1'b1;
					match_d  = 1'b0;
					res_load = 1'b1;
				end
			end
			rls_pkg::ST_BAT: begin
				if (rej_q) begin
					res_load = 1'b1;
				end else if (match_q && cursor_q != '0 && cursor_q <= cnt_u) begin
					rd_en   = 1'b1;
					rd_addr = AW'(cursor_q - 1'b1);
				end else begin
					match_d    = 1'b0;
					do_push    = 1'b1;
					push_batch = 1'b1;
				end
			end
			rls_pkg::ST_CMP: begin
				if (rd_term_q == cur_q.entry_term) begin
					cursor_d = cursor_q + 1'b1;
					res_load = 1'b1;
					res_acc  = 1'b1;
				end else begin
					// Conflict: drop the tail from here and append in its place.
					match_d    = 1'b0;
					do_push    = 1'b1;
					push_batch = 1'b1;
					push_base  = CW'(cursor_q - 1'b1);
				end
			end
			rls_pkg::ST_RD: begin
				res_load    = 1'b1;
				res_acc     = 1'b1;
				res_is_read = 1'b1;
			end
			default: begin
			end
		endcase
		if (do_push) begin
			res_load = 1'b1;
			if (push_base >= CW'(LOG_DEPTH)) begin
				res_full = 1'b1;
			end else begin
				res_acc     = 1'b1;
				wr_en       = 1'b1;
				wr_addr     = AW'(push_base);
				cnt_d       = push_base + 1'b1;
				last_term_d = cur_q.entry_term;
				if (push_batch) begin
					cursor_d = CUW'(push_base) + CUW'(2);
				end
			end
		end
	end

	// Next state follows from what the current state does.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rls_pkg::ST_IDLE: begin
				if (pop) begin
					state_d = rls_pkg::ST_DEC;
				end
			end
			rls_pkg::ST_DEC: begin
				if (res_load) begin
					state_d = rls_pkg::ST_IDLE;
				end else if (rd_en) begin
					unique case (cur_q.req_type)
						rls_pkg::REQ_HEART: state_d = rls_pkg::ST_HB;
						rls_pkg::REQ_READ:  state_d = rls_pkg::ST_RD;
						default:            state_d = rls_pkg::ST_CHK;
					endcase
				end else begin
					state_d = rls_pkg::ST_BAT;
				end
			end
			rls_pkg::ST_CHK: begin
				state_d = res_load ? rls_pkg::ST_IDLE : rls_pkg::ST_BAT;
			end
			rls_pkg::ST_BAT: begin
				state_d = rd_en ? rls_pkg::ST_CMP : rls_pkg::ST_IDLE;
			end
			default: begin
				state_d = rls_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			term_mem[wr_addr] <= cur_q.entry_term;
			cmd_mem[wr_addr]  <= cur_q.entry_command;
			key_mem[wr_addr]  <= cur_q.entry_key[PAYLOAD_BITS-1:0];
			val_mem[wr_addr]  <= cur_q.entry_value[PAYLOAD_BITS-1:0];
		end
		if (rd_en) begin
			rd_term_q <= term_mem[rd_addr];
			rd_cmd_q  <= cmd_mem[rd_addr];
			rd_key_q  <= key_mem[rd_addr];
			rd_val_q  <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_req;
		end
		if (res_load) begin
			res_q.accepted     <= res_acc;
			res_q.log_full     <= res_full;
			res_q.last_index   <= rls_pkg::IDX_W'(cnt_d);
			res_q.last_term    <= (cnt_d == '0) ? '0 : last_term_d;
			res_q.read_term    <= res_is_read ? rd_term_q : '0;
			res_q.read_command <= res_is_read ? rd_cmd_q : '0;
			res_q.read_key     <= res_is_read ? rls_pkg::WORD_W'(rd_key_q) : '0;
			res_q.read_value   <= res_is_read ? rls_pkg::WORD_W'(rd_val_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rls_pkg::ST_IDLE;
			cnt_q       <= '0;
			cursor_q    <= '0;
			match_q     <= 1'b0;
			rej_q       <= 1'b0;
			last_term_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			cursor_q    <= cursor_d;
			match_q     <= match_d;
			rej_q       <= rej_d;
			last_term_q <= last_term_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign q_ready   = pop;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the replicated log store unit.
// ----------------------------------------------------------------------------
// A behavioral copy of the log runs beside the block and predicts every
// result item. A short directed table covers reset reads, the extremes of the
// fields, every request kind, skips, truncation and rejected batches. Random
// traffic follows, mostly well-formed leader batches. Then the log is filled
// to capacity to exercise dropped appends. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 1024;

	typedef logic [rls_pkg::TERM_W-1:0] term_t;
	typedef logic [rls_pkg::IDX_W-1:0]  idx_t;
	typedef logic [rls_pkg::CMD_W-1:0]  cmd_t;
	typedef logic [rls_pkg::WORD_W-1:0] word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [rls_pkg::IN_W-1:0]  s_tdata = '0;
	logic [1:0]                s_tuser = rls_pkg::REQ_APPEND;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [rls_pkg::OUT_W-1:0] m_tdata;

	replicated_log_store_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// Shadow copy of the log.
	term_t log_term [DEPTH];
	cmd_t  log_cmd  [DEPTH];
	word_t log_key  [DEPTH];
	word_t log_val  [DEPTH];
	int unsigned log_len = 0;
	int unsigned match_cursor = 0;
	bit in_compare = 0;
	bit batch_refused = 0;

	rls_pkg::res_t pending_results[$];
	int            error_count = 0;
	bit            quiet = 0;

	function automatic bit prev_ok(int unsigned idx, term_t term);
		if (idx == 0)
			return term == 0;
		if (idx > log_len)
			return 0;
		return log_term[idx-1] == term;
	endfunction

	function automatic bit push_entry(rls_pkg::req_t r);
		if (log_len >= DEPTH)
			return 0;
		log_term[log_len] = r.entry_term;
		log_cmd[log_len]  = r.entry_command;
		log_key[log_len]  = r.entry_key;
		log_val[log_len]  = r.entry_value;
		log_len++;
		return 1;
	endfunction

	function automatic rls_pkg::res_t log_apply(rls_pkg::req_t r);
		rls_pkg::res_t o;
		bit skipped;
		o = '0;
		case (r.req_type)
			rls_pkg::REQ_APPEND: begin
				if (push_entry(r))
					o.accepted = 1'b1;
				else
					o.log_full = 1'b1;
			end
			rls_pkg::REQ_BATCH: begin
				if (r.first_of_batch) begin
					if (prev_ok(r.prev_index, r.prev_term)) begin
						batch_refused = 0;
						in_compare = 1;
						match_cursor = r.prev_index + 1;
					end else begin
						batch_refused = 1;
						in_compare = 0;
					end
				end
				if (!batch_refused) begin
					skipped = 0;
					if (in_compare && match_cursor >= 1 && match_cursor <= log_len) begin
						if (log_term[match_cursor-1] == r.entry_term) begin
							match_cursor++;
							skipped = 1;
						end else begin
							log_len = match_cursor - 1;
							in_compare = 0;
						end
					end else begin
						in_compare = 0;
					end
					if (skipped) begin
						o.accepted = 1'b1;
					end else if (push_entry(r)) begin
						match_cursor = log_len + 1;
						o.accepted = 1'b1;
					end else begin
						o.log_full = 1'b1;
					end
				end
			end
			rls_pkg::REQ_HEART: begin
				o.accepted = prev_ok(r.prev_index, r.prev_term);
			end
			default: begin
				if (r.read_index >= 1 && r.read_index <= log_len) begin
					o.accepted     = 1'b1;
					o.read_term    = log_term[r.read_index-1];
					o.read_command = log_cmd[r.read_index-1];
					o.read_key     = log_key[r.read_index-1];
					o.read_value   = log_val[r.read_index-1];
				end
			end
		endcase
		o.last_index = idx_t'(log_len);
		o.last_term  = log_len != 0 ? log_term[log_len-1] : '0;
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	// Drives one item and records its expected result once it is accepted.
	task automatic send_req(rls_pkg::req_t r, bit typed, rls_pkg::res_t typed_res);
		rls_pkg::res_t pred;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 19) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = r.req_type;
		s_tdata  = {3'b000, r.entry_value, r.entry_key, r.entry_command, r.entry_term,
			r.read_index, r.prev_term, r.prev_index, r.first_of_batch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = log_apply(r);
		pending_results = {pending_results, (typed ? typed_res : pred)};
	endtask

	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(99) >= 19);

	always @(posedge clk) begin
		rls_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result item at %0t", $realtime);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.accepted)
					report_mismatch("accepted", m_tdata[0], want.accepted);
				if (m_tdata[1] !== want.log_full)
					report_mismatch("log_full", m_tdata[1], want.log_full);
				if (m_tdata[12:2] !== want.last_index)
					report_mismatch("last_index", m_tdata[12:2], want.last_index);
				if (m_tdata[43:13] !== want.last_term)
					report_mismatch("last_term", m_tdata[43:13], want.last_term);
				if (m_tdata[74:44] !== want.read_term)
					report_mismatch("read_term", m_tdata[74:44], want.read_term);
				if (m_tdata[82:75] !== want.read_command)
					report_mismatch("read_command", m_tdata[82:75], want.read_command);
				if (m_tdata[146:83] !== want.read_key)
					report_mismatch("read_key", m_tdata[146:83], want.read_key);
				if (m_tdata[210:147] !== want.read_value)
					report_mismatch("read_value", m_tdata[210:147], want.read_value);
			end
		end
	end

	function automatic rls_pkg::req_t make_req(rls_pkg::req_kind_t kind, bit first,
			int unsigned pidx, term_t pterm, int unsigned ridx, term_t eterm,
			cmd_t cmd, word_t key, word_t val);
		rls_pkg::req_t r;
		r.req_type = kind;
		r.first_of_batch = first;
		r.prev_index = idx_t'(pidx);
		r.prev_term = pterm;
		r.read_index = idx_t'(ridx);
		r.entry_term = eterm;
		r.entry_command = cmd;
		r.entry_key = key;
		r.entry_value = val;
		return r;
	endfunction

	function automatic term_t pick_term();
		if ($urandom_range(9) == 0)
			return term_t'($urandom);
		return term_t'($urandom_range(6));
	endfunction

	// Random request with random payload; the other fields stay at random too.
	function automatic rls_pkg::req_t noise_req(rls_pkg::req_kind_t kind);
		return make_req(kind, 1'($urandom_range(1)), $urandom_range(DEPTH),
			$urandom_range(3) == 0 ? term_t'($urandom) : pick_term(), $urandom_range(DEPTH),
			pick_term(), cmd_t'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	typedef struct {
		rls_pkg::req_t r;
		bit            typed;
		rls_pkg::res_t want;
	} stim_row_t;

	localparam word_t ONES = '1;
	localparam term_t TMAX = '1;

	initial begin
		stim_row_t table_rows[$];
		stim_row_t row;
		rls_pkg::req_t r;
		rls_pkg::res_t z;
		int unsigned pidx, n, blen;

		z = '0;
		row.typed = 0;
		row.want = z;
		// Read of index zero right after reset: nothing is found.
		row.r = make_req(rls_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0); row.typed = 1;
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_HEART, 0, 0, 0, 0, 0, 0, 0, 0); row.want.accepted = 1;
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_HEART, 0, 0, 5, 0, 0, 0, 0, 0); row.want = z;
		table_rows = {table_rows, row};
		row.typed = 0;
		// Batch entry with no batch start seen since reset is appended.
		row.r = make_req(rls_pkg::REQ_BATCH, 0, 0, 0, 0, 3, 8'h11, 64'h1, 64'h2);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_APPEND, 0, 0, 0, 0, TMAX, 8'hff, ONES, ONES);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_READ, 0, 0, 0, 2, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_READ, 0, DEPTH, TMAX, DEPTH, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_HEART, 0, DEPTH, TMAX, 0, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_HEART, 0, 3, 0, 0, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_HEART, 0, 2, TMAX, 0, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		// Matching entry is skipped, then the batch runs past the end.
		row.r = make_req(rls_pkg::REQ_BATCH, 1, 1, 3, 0, TMAX, 8'h22, 64'h3, 64'h4);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_BATCH, 0, 0, 0, 0, 4, 8'h33, 64'h5, 64'h6);
		table_rows = {table_rows, row};
		// Conflict at index 2 truncates the log there.
		row.r = make_req(rls_pkg::REQ_BATCH, 1, 1, 3, 0, 9, 8'h44, 64'h7, 64'h8);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_READ, 0, 0, 0, 3, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		// Previous entry mismatch rejects the whole batch.
		row.r = make_req(rls_pkg::REQ_BATCH, 1, 2, 8, 0, 1, 8'h55, 64'h9, 64'ha);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_BATCH, 0, 0, 0, 0, 1, 8'h66, 64'hb, 64'hc);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_APPEND, 0, 0, 0, 0, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_READ, 0, 0, 0, 3, 0, 0, 0, 0);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_BATCH, 1, 0, 0, 0, 3, 8'h77, 64'hd, 64'he);
		table_rows = {table_rows, row};
		row.r = make_req(rls_pkg::REQ_BATCH, 1, 1, 4, 0, 3, 8'h88, 64'hf, 64'h10);
		table_rows = {table_rows, row};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (table_rows[i])
			send_req(table_rows[i].r, table_rows[i].typed, table_rows[i].want);

		n = 0;
		while (n < 550) begin
			quiet = (n >= 250 && n < 330);
			if ($urandom_range(99) < 55) begin
				// Well-formed batch against the current log, with random content.
				pidx = $urandom_range(log_len);
				r = make_req(rls_pkg::REQ_BATCH, 1, pidx, pidx == 0 ? '0 : log_term[pidx-1], 0,
					0, cmd_t'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
				if ($urandom_range(9) == 0)
					r.prev_term = pick_term();
				blen = $urandom_range(6, 1);
				for (int unsigned j = 0; j < blen; j++) begin
					r.entry_term = (pidx + j < log_len && $urandom_range(2) != 0) ?
						log_term[pidx+j] : pick_term();
					r.entry_command = cmd_t'($urandom);
					r.entry_key = {$urandom, $urandom};
					r.entry_value = {$urandom, $urandom};
					r.first_of_batch = (j == 0);
					send_req(r, 0, z);
					n++;
				end
			end else begin
				case ($urandom_range(3))
					0: r = noise_req(rls_pkg::REQ_APPEND);
					1: r = noise_req(rls_pkg::REQ_BATCH);
					2: begin
						r = noise_req(rls_pkg::REQ_HEART);
						if ($urandom_range(1) && log_len != 0) begin
							r.prev_index = idx_t'($urandom_range(log_len, 1));
							r.prev_term = log_term[r.prev_index-1];
						end
					end
					default: begin
						r = noise_req(rls_pkg::REQ_READ);
						if ($urandom_range(3) != 0)
							r.read_index = idx_t'($urandom_range(log_len));
					end
				endcase
				send_req(r, 0, z);
				n++;
			end
		end
		quiet = 0;

		// Fill the log to capacity, then hit it with appends of both kinds.
		while (log_len < DEPTH)
			send_req(noise_req(rls_pkg::REQ_APPEND), 0, z);
		send_req(noise_req(rls_pkg::REQ_APPEND), 0, z);
		r = noise_req(rls_pkg::REQ_BATCH);
		r.first_of_batch = 1;
		r.prev_index = idx_t'(DEPTH);
		r.prev_term = log_term[DEPTH-1];
		send_req(r, 0, z);
		r.first_of_batch = 0;
		send_req(r, 0, z);
		send_req(make_req(rls_pkg::REQ_HEART, 0, DEPTH, log_term[DEPTH-1], 0, 0, 0, 0, 0), 0, z);
		send_req(make_req(rls_pkg::REQ_READ, 0, 0, 0, DEPTH, 0, 0, 0, 0), 0, z);
		// A conflicting batch shortens the full log, so appends work again.
		r = make_req(rls_pkg::REQ_BATCH, 1, 0, 0, 0, log_term[0] + 1'b1, 1, 2, 3);
		send_req(r, 0, z);
		send_req(noise_req(rls_pkg::REQ_APPEND), 0, z);
		for (int j = 0; j < 10; j++)
			send_req(noise_req(rls_pkg::REQ_READ), 0, z);
		@(negedge clk);
		s_tvalid = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("PASS replicated_log_store_unit");
		else
			$display("FAIL replicated_log_store_unit");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL replicated_log_store_unit");
		$finish;
	end

endmodule

/* replicated_log_store_unit.f */
+incdir+design
design/rls_pkg.sv
design/rls_front.sv
design/rls_back.sv
design/replicated_log_store_unit.sv
verif/testbench.sv
